// File: rtl/core/siq_pkg.sv
// Shared types and codes for the sorted-insert priority queue.
package siq_pkg;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 7;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ENQ = 2'd0,
		ST_OVF = 2'd1,
		ST_DEQ = 2'd2,
		ST_UNF = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_INS,
		S_DEQ_WAIT,
		S_OUT
	} state_t;

	// Which logical slot the shared slot mapper resolves this cycle.
	typedef enum logic [1:0] {
		IDX_HEAD,
		IDX_SECOND,
		IDX_POS,
		IDX_POS_M1
	} idx_sel_t;

	typedef struct packed {
		logic [PRIO_W-1:0]         prio;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	// Strobes from the sequencer to the datapath.
	typedef struct packed {
		logic     rd_en;
		logic     wr_en;
		logic     wr_new;
		idx_sel_t idx_sel;
	} ctrl_t;

endpackage

// File: rtl/core/siq_req_if.sv
// Request channel: operation, value and priority of one queue word.
interface siq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic signed [siq_pkg::VALUE_W-1:0]   value;
	logic [siq_pkg::PRIO_W-1:0]           priority_req;

	modport source (output valid, output operation, output value, output priority_req,
		input ready);
	modport sink (input valid, input operation, input value, input priority_req,
		output ready);
endinterface

// File: rtl/core/siq_rsp_if.sv
// Response channel: dequeued data, status code and occupancy.
interface siq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [siq_pkg::VALUE_W-1:0]   data_out;
	logic [siq_pkg::STAT_W-1:0]           status;
	logic [siq_pkg::OCC_W-1:0]            occupancy;

	modport source (output valid, output data_out, output status, output occupancy,
		input ready);
	modport sink (input valid, input data_out, input status, input occupancy,
		output ready);
endinterface

// File: rtl/core/siq_slot_map.sv
// Logical queue slot to physical store address, modulo the store depth.
module siq_slot_map #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic [AW-1:0] head,
	input  logic [AW-1:0] idx,
	output logic [AW-1:0] addr
);
	logic [AW:0] sum;

	// Both operands stay below DEPTH, so one conditional subtract wraps.
	always_comb begin
		sum = {1'b0, head} + {1'b0, idx};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		addr = sum[AW-1:0];
	end
endmodule

// File: rtl/core/sorted_insert_priority_queue_core.sv
// Sorted-insert priority queue: circular store, sequencer and one shared slot mapper.
// An enqueue reads r entries through the single store port (k + 1 when k lower-priority
// entries move back, k when the word lands at the head, 0 into an empty queue), then
// writes the word in S_INS; a dequeue reads the head, overflow and underflow skip to S_OUT.
// Every answer leaves from S_OUT, held by rsp; req.ready is high only in idle.
// Reset clears the count, head pointer and handshake state; the store is not cleared.
module sorted_insert_priority_queue_core #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	siq_req_if.sink  req,
	siq_rsp_if.source rsp
);
	import siq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Store: one write and one registered read per cycle.
	entry_t         mem [DEPTH];
	entry_t         rd_data_q;

	state_t         state_q, state_d;
	ctrl_t          ctrl;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  pos_q;
	logic [AW-1:0]  head_q;
	logic [AW-1:0]  idx;
	logic [AW-1:0]  slot_addr;
	logic [AW-1:0]  pos_m1;

	// Word under work and its pending result.
	logic [PRIO_W-1:0]         pri_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] res_data_q;
	status_t                   res_status_q;

	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] rsp_data_q;
	status_t                   rsp_status_q;
	logic [OCC_W-1:0]          rsp_occ_q;

	logic [CW+OCC_W-1:0]       count_ext;
	logic                      shift_more;
	logic                      rsp_free;

	assign req.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.data_out  = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;

	assign rsp_free   = !rsp_valid_q || rsp.ready;
	// Move the entry one slot back while it ranks strictly below the new word.
	assign shift_more = (rd_data_q.prio < pri_q);
	assign pos_m1     = AW'(pos_q - CW'(1));
	// Report occupancy as the count folded to the field width.
	assign count_ext  = {{OCC_W{1'b0}}, count_q};

	// Select the logical slot for the shared mapper.
	always_comb begin
		case (ctrl.idx_sel)
			IDX_HEAD:   idx = '0;
			IDX_SECOND: idx = AW'(1);
			IDX_POS:    idx = AW'(pos_q);
			IDX_POS_M1: idx = pos_m1;
			default:    idx = '0;
		endcase
	end

	siq_slot_map #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_slot_map (
		.head (head_q),
		.idx  (idx),
		.addr (slot_addr)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (req.operation == OP_ENQ) begin
						if (count_q == CW'(DEPTH)) begin
							state_d = S_OUT;
						end else if (count_q == '0) begin
							state_d = S_INS;
						end else begin
							state_d = S_RD;
						end
					end else begin
						state_d = (count_q == '0) ? S_OUT : S_DEQ_WAIT;
					end
				end
			end
			S_RD:       state_d = S_CMP;
			S_CMP: begin
				if (shift_more && pos_q != CW'(1)) begin
					state_d = S_RD;
				end else begin
					state_d = S_INS;
				end
			end
			S_INS:      state_d = S_OUT;
			S_DEQ_WAIT: state_d = S_OUT;
			S_OUT: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Sequencer strobes.
	always_comb begin
		ctrl = '{rd_en: 1'b0, wr_en: 1'b0, wr_new: 1'b0, idx_sel: IDX_HEAD};
		case (state_q)
			S_IDLE: begin
				ctrl.rd_en   = req.valid && (req.operation == OP_DEQ);
				ctrl.idx_sel = IDX_HEAD;
			end
			S_RD: begin
				ctrl.rd_en   = 1'b1;
				ctrl.idx_sel = IDX_POS_M1;
			end
			S_CMP: begin
				ctrl.wr_en   = shift_more;
				ctrl.idx_sel = IDX_POS;
			end
			S_INS: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_new  = 1'b1;
				ctrl.idx_sel = IDX_POS;
			end
			S_DEQ_WAIT: ctrl.idx_sel = IDX_SECOND;
			S_OUT:      ctrl.idx_sel = IDX_HEAD;
			default:    ctrl.idx_sel = IDX_HEAD;
		endcase
	end

	// Store port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[slot_addr] <= ctrl.wr_new ? entry_t'{prio: pri_q, value: val_q} : rd_data_q;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[slot_addr];
		end
	end

	// Word registers and pending result; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					pri_q      <= req.priority_req;
					val_q      <= req.value;
					pos_q      <= count_q;
					res_data_q <= '0;
					if (req.operation == OP_ENQ) begin
						res_status_q <= ST_OVF;
					end else begin
						res_status_q <= ST_UNF;
					end
				end
			end
			S_CMP: begin
				if (shift_more) begin
					pos_q <= pos_q - CW'(1);
				end
			end
			S_INS:      res_status_q <= ST_ENQ;
			S_DEQ_WAIT: begin
				res_data_q   <= rd_data_q.value;
				res_status_q <= ST_DEQ;
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, count, head pointer, response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INS) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_DEQ_WAIT) begin
				// Advance the head past the removed entry.
				count_q <= count_q - CW'(1);
				head_q  <= slot_addr;
			end
			if (state_q == S_OUT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; loads only as the result leaves the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && rsp_free) begin
			rsp_data_q   <= res_data_q;
			rsp_status_q <= res_status_q;
			rsp_occ_q    <= count_ext[OCC_W-1:0];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_CMP) |-> (pos_q != '0 && pos_q <= count_q))
		else $error("insert position out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("sequencer idle after accepting a word");

	a_unf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == ST_UNF || rsp_status_q == ST_OVF
			|| rsp_status_q == ST_ENQ)) |-> (rsp_data_q == '0))
		else $error("nonzero data on a response without dequeue");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |-> (count_q != CW'(DEPTH)))
		else $error("insert into a full store");

endmodule
